/* src/cau_pkg.sv */
// Shared types, constants and datapath helpers of the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int INT_BITS    = 32 - FRAC_BITS;
    localparam int QBITS       = 33;
    localparam int NW          = 65 + FRAC_BITS;
    localparam int RB_IDX      = (FRAC_BITS == 0) ? 0 : FRAC_BITS - 1;
    localparam int DIV_STAGES  = QBITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cau_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } cau_status_t;

    typedef enum logic [1:0] {
        K_ADDSUB = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2,
        K_DIVZ   = 2'd3
    } cau_kind_t;

    typedef struct packed {
        cau_kind_t   kind;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] mag_re;
        logic [63:0] mag_im;
        logic [63:0] den;
    } cau_item_t;

    typedef struct packed {
        cau_item_t        item;
        logic             ovf_re;
        logic             ovf_im;
        logic [63:0]      rem_re;
        logic [63:0]      rem_im;
        logic [QBITS-1:0] q_re;
        logic [QBITS-1:0] q_im;
    } cau_stage_t;

    function automatic logic [QBITS-1:0] div_bits(input logic [63:0] mag);
        logic [NW-1:0] n;
        n = {mag, {(FRAC_BITS + 1){1'b0}}};
        return n[QBITS-1:0];
    endfunction

    function automatic logic [64:0] div_step(input logic [63:0] rem, input logic nbit,
                                             input logic [63:0] den);
        logic [64:0] t;
        logic [64:0] diff;
        t    = {rem, nbit};
        diff = t - {1'b0, den};
        if (diff[64]) begin
            return {t[63:0], 1'b0};
        end
        return {diff[63:0], 1'b1};
    endfunction

endpackage

/* src/cau_front.sv */
// Front end: operand register, product stage, sum stage and sign-magnitude classification.
module cau_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [127:0]       s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [1:0]         s_tuser,   // req_type
    output logic               out_valid,
    input  logic               out_ready,
    output cau_pkg::cau_item_t out_item
);
    import cau_pkg::*;

    logic               adv;
    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    cau_op_t            op0_reg, op1_reg, op2_reg;
    logic signed [31:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [63:0] prr_reg, pii_reg, pri_reg, pir_reg, pbr_reg, pbi_reg;
    logic signed [32:0] sre_reg, sim_reg;
    logic signed [64:0] re_reg, im_reg, re_next, im_next;
    logic [63:0]        den_reg;
    cau_item_t          item_reg, item_next;
    logic signed [32:0] sre_next, sim_next;

    assign adv       = !v3_reg || out_ready;
    assign s_tready  = adv;
    assign out_valid = v3_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb begin
        if (op0_reg == OP_SUB) begin
            sre_next = 33'(ar_reg) - 33'(br_reg);
            sim_next = 33'(ai_reg) - 33'(bi_reg);
        end else begin
            sre_next = 33'(ar_reg) + 33'(br_reg);
            sim_next = 33'(ai_reg) + 33'(bi_reg);
        end
    end

    always_comb begin
        unique case (op1_reg)
            OP_ADD, OP_SUB: begin
                re_next = 65'(sre_reg);
                im_next = 65'(sim_reg);
            end
            OP_MUL: begin
                re_next = 65'(prr_reg) - 65'(pii_reg);
                im_next = 65'(pri_reg) + 65'(pir_reg);
            end
            default: begin
                re_next = 65'(prr_reg) + 65'(pii_reg);
                im_next = 65'(pir_reg) - 65'(pri_reg);
            end
        endcase
    end

    always_comb begin
        item_next.neg_re = re_reg[64];
        item_next.neg_im = im_reg[64];
        item_next.mag_re = re_reg[64] ? 64'(-re_reg) : re_reg[63:0];
        item_next.mag_im = im_reg[64] ? 64'(-im_reg) : im_reg[63:0];
        item_next.den    = den_reg;
        unique case (op2_reg)
            OP_ADD, OP_SUB: item_next.kind = K_ADDSUB;
            OP_MUL:         item_next.kind = K_MUL;
            default:        item_next.kind = (den_reg == 64'd0) ? K_DIVZ : K_DIV;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op0_reg  <= cau_op_t'(s_tuser);
            ar_reg   <= s_tdata[31:0];
            ai_reg   <= s_tdata[63:32];
            br_reg   <= s_tdata[95:64];
            bi_reg   <= s_tdata[127:96];
            op1_reg  <= op0_reg;
            prr_reg  <= ar_reg * br_reg;
            pii_reg  <= ai_reg * bi_reg;
            pri_reg  <= ar_reg * bi_reg;
            pir_reg  <= ai_reg * br_reg;
            pbr_reg  <= br_reg * br_reg;
            pbi_reg  <= bi_reg * bi_reg;
            sre_reg  <= sre_next;
            sim_reg  <= sim_next;
            op2_reg  <= op1_reg;
            re_reg   <= re_next;
            im_reg   <= im_next;
            den_reg  <= 64'(pbr_reg) + 64'(pbi_reg);
            item_reg <= item_next;
        end
    end

endmodule

/* src/cau_queue.sv */
// Short queue between front end and back end.
module cau_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cau_pkg::cau_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cau_pkg::cau_item_t out_item
);
    import cau_pkg::*;

    cau_item_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                push, pop;

    assign in_ready  = cnt_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_push_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not grow on push");
    a_pop_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count did not shrink on pop");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers apart while empty");
`endif

endmodule

/* src/cau_back.sv */
// Back end: pipelined restoring divider, rounding, saturation and output register.
module cau_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cau_pkg::cau_item_t in_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,   // res_re, res_im
    output logic [1:0]         m_tuser    // status
);
    import cau_pkg::*;

    logic              adv;
    logic [DIV_STAGES:0] vld_reg;
    cau_stage_t        st_reg  [DIV_STAGES+1];
    cau_stage_t        st_next [DIV_STAGES+1];
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign in_ready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    function automatic logic [32:0] sat_part(input logic neg, input logic [64:0] rmag);
        logic sat;
        logic [31:0] val;
        if (neg) begin
            sat = rmag > 65'h0_8000_0000;
            val = sat ? 32'h8000_0000 : 32'(-rmag[31:0]);
        end else begin
            sat = rmag > 65'h0_7FFF_FFFF;
            val = sat ? 32'h7FFF_FFFF : rmag[31:0];
        end
        return {sat, val};
    endfunction

    function automatic logic [64:0] round_part(input cau_kind_t kind, input logic [63:0] mag,
                                              input logic ovf, input logic [QBITS-1:0] q);
        logic rb;
        logic [QBITS:0] qr;
        rb = (FRAC_BITS == 0) ? 1'b0 : mag[RB_IDX];
        qr = (QBITS + 1)'(q) + 1'b1;
        unique case (kind)
            K_ADDSUB: return {1'b0, mag};
            K_MUL:    return 65'(mag >> FRAC_BITS) + 65'(rb);
            K_DIV:    return ovf ? 65'h1_0000_0000 : 65'(qr >> 1);
            default:  return '0;
        endcase
    endfunction

    for (genvar s = 0; s <= DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_entry
            always_comb begin
                st_next[0].item   = in_item;
                st_next[0].rem_re = 64'(in_item.mag_re >> INT_BITS);
                st_next[0].rem_im = 64'(in_item.mag_im >> INT_BITS);
                st_next[0].ovf_re = st_next[0].rem_re >= in_item.den;
                st_next[0].ovf_im = st_next[0].rem_im >= in_item.den;
                st_next[0].q_re   = '0;
                st_next[0].q_im   = '0;
            end
        end else begin : g_div
            logic [QBITS-1:0] nb_re, nb_im;
            logic [64:0]      r_re, r_im;
            always_comb begin
                nb_re = div_bits(st_reg[s-1].item.mag_re);
                nb_im = div_bits(st_reg[s-1].item.mag_im);
                r_re  = div_step(st_reg[s-1].rem_re, nb_re[QBITS-s], st_reg[s-1].item.den);
                r_im  = div_step(st_reg[s-1].rem_im, nb_im[QBITS-s], st_reg[s-1].item.den);
                st_next[s]        = st_reg[s-1];
                st_next[s].rem_re = r_re[64:1];
                st_next[s].rem_im = r_im[64:1];
                st_next[s].q_re   = {st_reg[s-1].q_re[QBITS-2:0], r_re[0]};
                st_next[s].q_im   = {st_reg[s-1].q_im[QBITS-2:0], r_im[0]};
            end
        end
    end

    always_comb begin
        logic [32:0] pre, pim;
        pre = sat_part(st_reg[DIV_STAGES].item.neg_re,
                       round_part(st_reg[DIV_STAGES].item.kind, st_reg[DIV_STAGES].item.mag_re,
                                  st_reg[DIV_STAGES].ovf_re, st_reg[DIV_STAGES].q_re));
        pim = sat_part(st_reg[DIV_STAGES].item.neg_im,
                       round_part(st_reg[DIV_STAGES].item.kind, st_reg[DIV_STAGES].item.mag_im,
                                  st_reg[DIV_STAGES].ovf_im, st_reg[DIV_STAGES].q_im));
        if (st_reg[DIV_STAGES].item.kind == K_DIVZ) begin
            m_tdata_next = '0;
            m_tuser_next = ST_DIVZ;
        end else begin
            m_tdata_next = {pim[31:0], pre[31:0]};
            m_tuser_next = (pre[32] || pim[32]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[DIV_STAGES-1:0], in_valid};
            m_tvalid_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= DIV_STAGES; i++) begin
                st_reg[i] <= st_next[i];
            end
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

endmodule

/* src/complex_arithmetic_unit_top.sv */
// Top level of the complex arithmetic unit: front end, queue and back end.
//
//  channel  | direction | tdata                        | tuser
//  s_*      | in        | a_re, a_im, b_re, b_im       | req_type
//  m_*      | out       | res_re, res_im               | status
//
// One transfer in and one result out per cycle sustained while m_tready stays high.
// After the accepting edge a result passes three further front stages, one queue slot,
// a divider entry stage, a 33-stage restoring divider (one quotient bit per stage) and
// the output register.
// Reset clears valid flags, queue pointers and the queue count only; no clearing pass.
// A stalled m_tready freezes the back end; s_tready falls once the four-entry queue
// is full and the last front stage holds an item.
module complex_arithmetic_unit_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [1:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_re, res_im
    output logic [1:0]   m_tuser    // status
);
    import cau_pkg::*;

    logic      f_valid, f_ready, q_valid, q_ready;
    cau_item_t f_item, q_item;

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    cau_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    cau_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* verif/tb_complex_arithmetic_unit_top.sv */
// Testbench of the complex arithmetic unit: directed table then random operations, checked in order.
module tb_complex_arithmetic_unit_top;
    import cau_pkg::*;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        cau_status_t st;
    } cplx_result_t;

    typedef struct {
        cau_op_t     op;
        logic [31:0] ar, ai, br, bi;
        bit          typed;
        logic [31:0] ere, eim;
        cau_status_t est;
    } dir_row_t;

    localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] QMIN = 32'h8000_0000;
    localparam logic [31:0] QONE = 32'h0001_0000;
    localparam int N_RANDOM = 1030;
    localparam int N_DIR = 20;
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    cplx_result_t pending_q[$];
    int           n_err = 0;
    int           n_cycles = 0;
    bit           typed_q[$];
    cplx_result_t typed_val_q[$];
    dir_row_t     dir_rows [N_DIR];

    complex_arithmetic_unit_top uut (.*);

    always #4 aclk = ~aclk;

    function automatic logic [31:0] clip32(logic neg, logic [64:0] mag, ref bit sat);
        if (!neg) begin
            if (mag > 65'h7FFF_FFFF) begin
                sat = 1;
                return QMAX;
            end
            return mag[31:0];
        end
        if (mag > 65'h8000_0000) begin
            sat = 1;
            return QMIN;
        end
        return 32'(-mag);
    endfunction

    function automatic logic [64:0] quot_round(logic [64:0] mag, logic [63:0] d);
        logic [65:0] q, rem;
        q   = mag / d;
        rem = mag % d;
        if ((q >> (32 - FRAC_BITS)) != 0) begin
            return 65'h1_0000_0000;
        end
        for (int i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q[0] = 1'b1;
            end
        end
        if ((rem << 1) >= d) begin
            q = q + 1;
        end
        return q[64:0];
    endfunction

    function automatic cplx_result_t complex_op(cau_op_t op, logic [31:0] ar, logic [31:0] ai,
                                                logic [31:0] br, logic [31:0] bi);
        logic signed [65:0] xr, xi, yr, yi, nr, ni;
        logic [64:0]        mr, mi;
        logic [63:0]        den;
        bit                 sat;
        cplx_result_t       r;
        xr = $signed(ar);
        xi = $signed(ai);
        yr = $signed(br);
        yi = $signed(bi);
        sat = 0;
        case (op)
            OP_ADD: begin
                nr = xr + yr;
                ni = xi + yi;
            end
            OP_SUB: begin
                nr = xr - yr;
                ni = xi - yi;
            end
            OP_MUL: begin
                nr = xr * yr - xi * yi;
                ni = xr * yi + xi * yr;
            end
            default: begin
                nr = xr * yr + xi * yi;
                ni = xi * yr - xr * yi;
            end
        endcase
        mr = nr[65] ? 65'(-nr) : 65'(nr);
        mi = ni[65] ? 65'(-ni) : 65'(ni);
        if (op == OP_MUL) begin
            mr = (mr >> FRAC_BITS) + mr[FRAC_BITS-1];
            mi = (mi >> FRAC_BITS) + mi[FRAC_BITS-1];
        end else if (op == OP_DIV) begin
            den = 64'(yr * yr) + 64'(yi * yi);
            if (den == 0) begin
                r.re = '0;
                r.im = '0;
                r.st = ST_DIVZ;
                return r;
            end
            mr = quot_round(mr, den);
            mi = quot_round(mi, den);
        end
        r.re = clip32(nr[65], mr, sat);
        r.im = clip32(ni[65], mi, sat);
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 7))
            0:       return QMAX;
            1:       return QMIN;
            2:       return 32'($signed($urandom_range(0, 8)) - 4);
            3, 4:    return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Predict on accepted input, compare on accepted output
    always @(posedge aclk) begin
        cplx_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h st=%0d", $time,
                         m_tdata[31:0], m_tdata[63:32], m_tuser);
                n_err++;
            end else begin
                exp_r = pending_q.pop_front();
                if (m_tdata[31:0] !== exp_r.re || m_tdata[63:32] !== exp_r.im
                    || m_tuser !== exp_r.st) begin
                    $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                             $time, exp_r.re, exp_r.im, exp_r.st,
                             m_tdata[31:0], m_tdata[63:32], m_tuser);
                    n_err++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            if (typed_q.pop_front()) begin
                pending_q.push_back(typed_val_q.pop_front());
            end else begin
                void'(typed_val_q.pop_front());
                pending_q.push_back(complex_op(cau_op_t'(s_tuser), s_tdata[31:0],
                                               s_tdata[63:32], s_tdata[95:64],
                                               s_tdata[127:96]));
            end
        end
    end

    // Result side back-pressure
    initial begin
        int k;
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (k > 0) begin
                m_tready <= 1'b0;
                repeat (k) @(posedge aclk);
            end
        end
    end

    task automatic send_op(cau_op_t op, logic [31:0] ar, logic [31:0] ai, logic [31:0] br,
                           logic [31:0] bi, bit typed, cplx_result_t tv, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        typed_q.push_back(typed);
        typed_val_q.push_back(tv);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bi, br, ai, ar};
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        cplx_result_t tv;
        bit           burst;
        int           run;
        cau_op_t      op;
        logic [31:0]  br, bi;
        dir_rows = '{
            '{OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 1, 32'd0, 32'd0, ST_OK},
            '{OP_ADD, QMAX, QMAX, QMAX, QMAX, 1, QMAX, QMAX, ST_SAT},
            '{OP_ADD, QMIN, QMIN, QMIN, QMIN, 1, QMIN, QMIN, ST_SAT},
            '{OP_SUB, QMIN, 32'd0, QMAX, 32'd0, 1, QMIN, 32'd0, ST_SAT},
            '{OP_SUB, QMAX, QMAX, QMIN, QMIN, 1, QMAX, QMAX, ST_SAT},
            '{OP_SUB, QMAX, QMIN, QMAX, QMIN, 1, 32'd0, 32'd0, ST_OK},
            '{OP_MUL, QONE, 32'd0, QONE, 32'd0, 1, QONE, 32'd0, ST_OK},
            '{OP_MUL, QMIN, QMIN, QMIN, QMIN, 0, 0, 0, ST_OK},
            '{OP_MUL, QMAX, QMIN, QMIN, QMAX, 0, 0, 0, ST_OK},
            '{OP_MUL, 32'd1, 32'd0, 32'h8000, 32'd0, 0, 0, 0, ST_OK},
            '{OP_MUL, 32'hFFFF_FFFF, 32'd1, 32'h8000, 32'h7FFF, 0, 0, 0, ST_OK},
            '{OP_DIV, QONE, QONE, 32'd0, 32'd0, 1, 32'd0, 32'd0, ST_DIVZ},
            '{OP_DIV, 32'd0, 32'd0, 32'd0, 32'd0, 1, 32'd0, 32'd0, ST_DIVZ},
            '{OP_DIV, QONE, 32'd0, QONE, 32'd0, 1, QONE, 32'd0, ST_OK},
            '{OP_DIV, QMIN, QMIN, QMIN, QMIN, 0, 0, 0, ST_OK},
            '{OP_DIV, QMAX, QMAX, 32'd1, 32'd0, 0, 0, 0, ST_OK},
            '{OP_DIV, QMIN, QMAX, QMAX, QMIN, 0, 0, 0, ST_OK},
            '{OP_DIV, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'd0, 0, 0, 0, ST_OK},
            '{OP_DIV, 32'd0, 32'd0, QMAX, 32'd5, 0, 0, 0, ST_OK},
            '{OP_DIV, 32'h0000_8000, 32'd0, 32'h0002_0000, 32'd0, 0, 0, 0, ST_OK}
        };
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            tv.re = dir_rows[i].ere;
            tv.im = dir_rows[i].eim;
            tv.st = dir_rows[i].est;
            send_op(dir_rows[i].op, dir_rows[i].ar, dir_rows[i].ai, dir_rows[i].br,
                    dir_rows[i].bi, dir_rows[i].typed, tv, i[0]);
        end
        run = 0;
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (run == 0) begin
                run = $urandom_range(1, 40);
                burst = ($urandom_range(0, 2) == 0);
            end
            run--;
            op = cau_op_t'($urandom_range(0, 3));
            br = rand_part();
            bi = rand_part();
            if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
                br = 32'd0;
                bi = 32'd0;
            end
            send_op(op, rand_part(), rand_part(), br, bi, 0, tv, burst);
        end
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (n_err == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/cau_pkg.sv
src/cau_front.sv
src/cau_queue.sv
src/cau_back.sv
src/complex_arithmetic_unit_top.sv
verif/tb_complex_arithmetic_unit_top.sv
